// ===== src/dial_scan_quantizer_unit_assert.svh =====
// Assertion macros for the dial scan quantizer.
// Used by dial_scan_quantizer_unit; expects clk and rst_n in scope.
`ifndef DIAL_SCAN_QUANTIZER_UNIT_ASSERT_SVH
`define DIAL_SCAN_QUANTIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define DSQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsq assertion failed");
`define DSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsq assertion failed");
`else
`define DSQ_ASSERT_SAME(lbl, ante, cons)
`define DSQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/dsq_pkg.sv =====
// Types and constants of the dial scan quantizer.
// Used by dsq_quantize and dial_scan_quantizer_unit; no dependencies.
package dsq_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int POS_W      = 4;
  localparam int DIAL_W     = 2;
  localparam int CHAN_W     = 4;
  localparam int DIAL_MAX   = 4;
  localparam int STEP_COUNT = 10;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [POS_W-1:0] POS_RESET = 4'd5;
  localparam logic [POS_W-1:0] POS_MAX   = 4'd10;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [DIAL_W-1:0]   dial_t;
  typedef logic [CHAN_W-1:0]   chan_t;

  typedef enum logic [DIAL_W-1:0] {
    REG_TONE   = 2'd0,
    REG_VOLUME = 2'd1,
    REG_RATE   = 2'd2,
    REG_WEIGHT = 2'd3
  } cfg_reg_t;

  localparam sample_t LADDER [STEP_COUNT] = '{
    10'd15, 10'd88, 10'd198, 10'd314, 10'd438,
    10'd577, 10'd702, 10'd817, 10'd929, 10'd1010
  };

  localparam chan_t CHAN_RESET [DIAL_MAX] = '{4'd0, 4'd1, 4'd2, 4'd3};

endpackage

// ===== src/dsq_quantize.sv =====
// Threshold ladder: maps a 10-bit sample to a dial position 0..10.
// Depends on dsq_pkg for the ladder table and widths.
module dsq_quantize (
  input  dsq_pkg::sample_t sample,
  output dsq_pkg::pos_t    position
);
  import dsq_pkg::*;

  always_comb begin
    position = '0;
    for (int k = 0; k < STEP_COUNT; k++) begin
      if (sample >= LADDER[k]) begin
        position = POS_W'(k + 1);
      end
    end
  end

endmodule

// ===== src/dial_scan_quantizer_unit.sv =====
// Dial scan quantizer: round-robin dial scan, ladder quantizing, change flag.
// A result reaches out_valid through the input register and then the result register.
// Throughput: one request per cycle; the two-stage pipeline stalls only on out_ready.
// Reset (rst_n, synchronous, active low): scan at dial 0, all stored positions 5,
// channel registers 0..3, pipeline empty.
// Depends on dsq_pkg, dsq_quantize and dial_scan_quantizer_unit_assert.svh.
`include "dial_scan_quantizer_unit_assert.svh"
module dial_scan_quantizer_unit #(
  parameter int DIAL_COUNT = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  dsq_pkg::sample_t         in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dsq_pkg::dial_t           out_dial_index,
  output dsq_pkg::pos_t            out_position,
  output logic                     out_changed,
  output dsq_pkg::chan_t           out_next_channel,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dsq_pkg::ADDR_W-1:0] paddr,
  input  logic [dsq_pkg::DATA_W-1:0] pwdata,
  output logic [dsq_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import dsq_pkg::*;

  chan_t    chan_r [DIAL_MAX];
  pos_t     last_pos_r [DIAL_MAX];
  dial_t    current_dial_r;
  dial_t    dial_nxt;
  logic     s1_valid_r;
  sample_t  s1_sample_r;
  logic     out_valid_r;
  dial_t    out_dial_index_r;
  pos_t     out_position_r;
  logic     out_changed_r;
  chan_t    out_next_channel_r;
  pos_t     pos;
  logic     advance;
  logic     move;
  logic     cfg_write;
  cfg_reg_t cfg_idx;

  dsq_quantize u_quantize (
    .sample   (s1_sample_r),
    .position (pos)
  );

  assign advance  = !out_valid_r || out_ready;
  assign move     = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  assign dial_nxt = (current_dial_r == DIAL_W'(DIAL_COUNT - 1)) ? '0 : current_dial_r + 1'b1;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign prdata    = DATA_W'(chan_r[paddr[ADDR_W-1:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIAL_MAX; k++) begin
        chan_r[k] <= CHAN_RESET[k];
      end
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_TONE:   chan_r[REG_TONE]   <= pwdata[CHAN_W-1:0];
        REG_VOLUME: chan_r[REG_VOLUME] <= pwdata[CHAN_W-1:0];
        REG_RATE:   chan_r[REG_RATE]   <= pwdata[CHAN_W-1:0];
        REG_WEIGHT: chan_r[REG_WEIGHT] <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_dial_r <= '0;
      out_valid_r    <= 1'b0;
      for (int k = 0; k < DIAL_MAX; k++) begin
        last_pos_r[k] <= POS_RESET;
      end
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (move) begin
        current_dial_r             <= dial_nxt;
        last_pos_r[current_dial_r] <= pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_dial_index_r   <= current_dial_r;
      out_position_r     <= pos;
      out_changed_r      <= (pos != last_pos_r[current_dial_r]);
      out_next_channel_r <= chan_r[dial_nxt];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dial_index   = out_dial_index_r;
  assign out_position     = out_position_r;
  assign out_changed      = out_changed_r;
  assign out_next_channel = out_next_channel_r;

  `DSQ_ASSERT_SAME(a_stored_matches, out_valid_r, last_pos_r[out_dial_index_r] == out_position_r)
  `DSQ_ASSERT_SAME(a_dial_in_range, 1'b1, current_dial_r <= DIAL_W'(DIAL_COUNT - 1))
  `DSQ_ASSERT_SAME(a_pos_in_range, out_valid_r, out_position_r <= POS_MAX)
  `DSQ_ASSERT_NEXT(a_dial_steps, move, current_dial_r == $past(dial_nxt))

endmodule

// ===== test/tb_dial_scan_quantizer_unit.sv =====
// Self-checking testbench for dial_scan_quantizer_unit: ladder edges, dial wrap,
// change flag and channel registers, checked against an in-bench scan predictor.
// Depends on dsq_pkg and the dial_scan_quantizer_unit RTL.
`timescale 1ns / 100ps
module tb_dial_scan_quantizer_unit;
  import dsq_pkg::*;

  localparam int DIALS = 4;
  localparam int PIPE_LATENCY = 2;
  localparam int ITEMS_PER_SETTING = 220;

  typedef struct packed {
    dial_t dial;
    pos_t  position;
    logic  changed;
    chan_t next_channel;
  } dial_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  sample_t           in_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  dial_t             out_dial_index;
  pos_t              out_position;
  logic              out_changed;
  chan_t             out_next_channel;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  chan_t        chan_shadow [DIAL_MAX];
  pos_t         pos_memory [DIAL_MAX];
  dial_t        scan_dial;
  dial_report_t pending_reports [$];
  int           failures = 0;
  int           accepted = 0;
  int           change_count = 0;
  int           setting_count = 0;
  bit           gaps_on = 1'b1;
  int           stall_left = 0;

  dial_scan_quantizer_unit #(.DIAL_COUNT(DIALS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_dial_index(out_dial_index), .out_position(out_position),
    .out_changed(out_changed), .out_next_channel(out_next_channel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(4_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic pos_t ladder_position(sample_t s);
    pos_t p;
    p = '0;
    for (int k = 0; k < STEP_COUNT; k++) begin
      if (s >= LADDER[k]) p = pos_t'(k + 1);
    end
    return p;
  endfunction

  function automatic dial_report_t predict_report(sample_t s);
    dial_report_t r;
    dial_t nxt;
    r.dial = scan_dial;
    r.position = ladder_position(s);
    r.changed = (r.position != pos_memory[scan_dial]);
    if (r.changed) begin
      pos_memory[scan_dial] = r.position;
      change_count++;
    end
    nxt = (int'(scan_dial) + 1 >= DIALS) ? dial_t'(0) : dial_t'(scan_dial + 1'b1);
    scan_dial = nxt;
    r.next_channel = chan_shadow[nxt];
    return r;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic sample_t pick_sample();
    int   mode;
    int   p;
    int   lo;
    int   hi;
    mode = $urandom_range(0, 9);
    if (mode < 3) return sample_t'($urandom_range(0, 1023));
    if (mode < 6) return sample_t'(int'(LADDER[$urandom_range(0, STEP_COUNT - 1)])
                                   + int'($urandom_range(0, 3)) - 2);
    // hold the dial inside its stored band so that no change is flagged
    p = pos_memory[scan_dial];
    lo = (p == 0) ? 0 : int'(LADDER[p - 1]);
    hi = (p == STEP_COUNT) ? 1023 : int'(LADDER[p]) - 1;
    return sample_t'($urandom_range(lo, hi));
  endfunction

  always @(posedge clk) begin : watch
    dial_report_t want;
    if (rst_n && in_valid && in_ready) begin
      pending_reports.push_back(predict_report(in_sample));
      accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want = pending_reports.pop_front();
        report_field("dial_index", want.dial, out_dial_index);
        report_field("position", want.position, out_position);
        report_field("changed", want.changed, out_changed);
        report_field("next_channel", want.next_channel, out_next_channel);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_access(input cfg_reg_t r, input bit wr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'({r, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) chan_shadow[r] = data[CHAN_W-1:0];
    else report_field("prdata", int'(chan_shadow[r]), int'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [4*CHAN_W-1:0] chans, input logic [27:0] upper);
    cfg_reg_t r;
    for (int i = 0; i < DIAL_MAX; i++) begin
      r = cfg_reg_t'(i);
      reg_access(r, 1'b1, {upper, chans[i*CHAN_W +: CHAN_W]});
    end
    for (int i = 0; i < DIAL_MAX; i++) begin
      r = cfg_reg_t'(i);
      reg_access(r, 1'b0, '0);
    end
    setting_count++;
  endtask

  task automatic test_reset_state();
    reg_access(REG_TONE, 1'b0, '0);
    reg_access(REG_VOLUME, 1'b0, '0);
    reg_access(REG_RATE, 1'b0, '0);
    reg_access(REG_WEIGHT, 1'b0, '0);
    repeat (3) send_sample(sample_t'(500));
    drain();
  endtask

  task automatic test_ladder_edges();
    send_sample('0);
    for (int k = 0; k < STEP_COUNT; k++) begin
      send_sample(LADDER[k] - 1'b1);
      send_sample(LADDER[k]);
    end
    send_sample('1);
    drain();
  endtask

  task automatic test_random_scan(input logic [4*CHAN_W-1:0] chans, input logic [27:0] upper);
    apply_setting(chans, upper);
    for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_sample(pick_sample());
    end
    gaps_on = 1'b1;
    drain();
  endtask

  initial begin
    for (int i = 0; i < DIAL_MAX; i++) begin
      chan_shadow[i] = CHAN_RESET[i];
      pos_memory[i] = POS_RESET;
    end
    scan_dial = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_ladder_edges();
    test_random_scan(16'hFFFF, 28'hFFF_FFFF);
    test_random_scan(16'h0000, 28'h000_0000);
    test_random_scan(16'h0123, 28'h5A5_A5A5);
    test_random_scan(16'($urandom), 28'($urandom));
    test_random_scan(16'($urandom), 28'($urandom));
    test_random_scan(16'hF00F, 28'h000_0001);

    $display("scan covered %0d requests over %0d channel settings plus reset values,",
             accepted, setting_count);
    $display("with %0d position changes flagged", change_count);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
